// ===== design/bdd_pkg.sv =====
package bdd_pkg;

    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COMP_W       = 8;
    localparam int PSUM_W       = COMP_W + 1;
    localparam int TOTAL_W      = COMP_W + 2;
    localparam int NCOMP        = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA  = 2'd2;

    typedef struct packed {
        logic [COMP_W-1:0] comp_0;
        logic [COMP_W-1:0] comp_1;
        logic [COMP_W-1:0] comp_2;
        logic [COMP_W-1:0] comp_3;
    } t_pix_in;

    typedef struct packed {
        logic [COMP_W-1:0] out_0;
        logic [COMP_W-1:0] out_1;
        logic [COMP_W-1:0] out_2;
        logic [COMP_W-1:0] out_3;
        logic              frame_end;
    } t_pix_out;

    // Four horizontal pair sums, one per component
    typedef logic [NCOMP-1:0][PSUM_W-1:0] t_psum_quad;

    // Per-transaction control from the front end to the combine stage
    typedef struct packed {
        logic emit;
        logic frame_end;
        logic single_row;
        logic has_alpha;
    } t_front;

endpackage

// ===== design/bdd_ctrl.sv =====
module bdd_ctrl #(
    parameter int MAX_WIDTH = 4096,
    parameter int AW        = 11
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_acc,
    input  bdd_pkg::t_pix_in                i_pix,
    output logic                            o_lb_wr,
    output logic                            o_lb_rd,
    output logic [AW-1:0]                   o_lb_addr,
    output bdd_pkg::t_psum_quad             o_hs,
    output bdd_pkg::t_front                 o_ctl
);
    import bdd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > CFG_W) ? WW : CFG_W;

    logic [CFG_W-1:0]                 r_cfg_w;
    logic [CFG_W-1:0]                 r_cfg_h;
    logic                             r_has_alpha;
    logic [CW-1:0]                    r_col;
    logic [CW-1:0]                    n_col;
    logic [ROW_W-1:0]                 r_row;
    logic [ROW_W-1:0]                 n_row;
    logic [NCOMP-1:0][COMP_W-1:0]     r_pend;
    logic [NCOMP-1:0][COMP_W-1:0]     n_pend;
    logic [NCOMP-1:0][COMP_W-1:0]     pix;

    logic [WW-1:0]    w_eff;
    logic [WW-1:0]    ow;
    logic [WW-1:0]    col_lim;
    logic [WW-1:0]    col_x;
    logic [WW-1:0]    col_half;
    logic [CFG_W-1:0] h_eff;
    logic [CFG_W-1:0] oh;
    logic [CFG_W-1:0] row_lim;
    logic [CFG_W-1:0] row_x;
    logic [CFG_W-1:0] row_half;
    logic             w_one;
    logic             h_one;
    logic             in_box;
    logic             pair_done;
    logic             odd_row;
    logic             cfg_hit;

    assign pix[0] = i_pix.comp_0;
    assign pix[1] = i_pix.comp_1;
    assign pix[2] = i_pix.comp_2;
    assign pix[3] = i_pix.comp_3;

    // Clamp the programmed dimensions
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (XW'(r_cfg_w) > XW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = CFG_W'(1);
        end else if (r_cfg_h > CFG_W'(HEIGHT_LIMIT)) begin
            h_eff = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    assign w_one    = (w_eff == WW'(1));
    assign h_one    = (h_eff == CFG_W'(1));
    assign ow       = w_one ? WW'(1) : (w_eff >> 1);
    assign oh       = h_one ? CFG_W'(1) : (h_eff >> 1);
    assign col_lim  = w_one ? WW'(2) : {w_eff[WW-1:1], 1'b0};
    assign row_lim  = h_one ? CFG_W'(2) : {h_eff[CFG_W-1:1], 1'b0};
    assign col_x    = WW'(r_col);
    assign row_x    = CFG_W'(r_row);
    assign col_half = col_x >> 1;
    assign row_half = row_x >> 1;

    assign in_box    = (col_x < col_lim) && (row_x < row_lim);
    assign pair_done = in_box && (w_one || r_col[0]);
    assign odd_row   = r_row[0];

    // Horizontal pair sum; a one-pixel-wide image pairs each pixel with itself
    always_comb begin
        for (int k = 0; k < NCOMP; k++) begin
            o_hs[k] = w_one ? {pix[k], 1'b0} : (PSUM_W'(r_pend[k]) + PSUM_W'(pix[k]));
        end
    end

    assign o_lb_wr   = i_acc && pair_done && !h_one && !odd_row;
    assign o_lb_rd   = i_acc && pair_done && !h_one && odd_row;
    assign o_lb_addr = AW'(col_half);

    assign o_ctl.emit       = pair_done && (h_one || odd_row);
    assign o_ctl.frame_end  = ((col_half + WW'(1)) == ow) && ((row_half + CFG_W'(1)) == oh);
    assign o_ctl.single_row = h_one;
    assign o_ctl.has_alpha  = r_has_alpha;

    always_comb begin
        unique case (i_cfg_idx)
            CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_HAS_ALPHA: cfg_hit = i_cfg_we;
            default:                                      cfg_hit = 1'b0;
        endcase
    end

    // Raster position and pending even-column pixel
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        if (cfg_hit) begin
            n_col  = '0;
            n_row  = '0;
            n_pend = '0;
        end else if (i_acc) begin
            if (in_box && !w_one && !r_col[0]) begin
                n_pend = pix;
            end
            if ((col_x + WW'(1)) >= w_eff) begin
                n_col = '0;
                if ((row_x + CFG_W'(1)) >= h_eff) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= CFG_W'(64);
            r_cfg_h     <= CFG_W'(64);
            r_has_alpha <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_pend      <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SRC_WIDTH:  r_cfg_w     <= i_cfg_data;
                    CFG_SRC_HEIGHT: r_cfg_h     <= i_cfg_data;
                    CFG_HAS_ALPHA:  r_has_alpha <= i_cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

// ===== design/bdd_line_buf.sv =====
module bdd_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                 i_clk,
    input  logic                 i_wr,
    input  logic                 i_rd,
    input  logic [AW-1:0]        i_addr,
    input  bdd_pkg::t_psum_quad  i_wdata,
    output bdd_pkg::t_psum_quad  o_rdata
);
    import bdd_pkg::*;

    t_psum_quad r_mem [DEPTH];
    t_psum_quad r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bdd_out.sv =====
module bdd_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  bdd_pkg::t_front      i_ctl,
    input  bdd_pkg::t_psum_quad  i_hs,
    input  bdd_pkg::t_psum_quad  i_line,
    input  logic                 i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_s1_vld,
    output logic                 o_out_vld,
    output bdd_pkg::t_pix_out    o_out_pix
);
    import bdd_pkg::*;

    logic                          r_s1_vld;
    t_front                        r_s1_ctl;
    t_psum_quad                    r_s1_hs;
    logic                          r_out_vld;
    t_pix_out                      r_out_pix;
    t_pix_out                      n_out_pix;
    logic [NCOMP-1:0][COMP_W-1:0]  avg;
    logic [TOTAL_W-1:0]            total;
    logic                          out_free;
    logic                          s1_go;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_go      = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;

    // Vertical sum and divide by four
    always_comb begin
        total = '0;
        for (int k = 0; k < NCOMP; k++) begin
            if (r_s1_ctl.single_row) begin
                total = {r_s1_hs[k], 1'b0};
            end else begin
                total = TOTAL_W'(i_line[k]) + TOTAL_W'(r_s1_hs[k]);
            end
            avg[k] = total[TOTAL_W-1:2];
        end
        n_out_pix.out_0     = avg[0];
        n_out_pix.out_1     = avg[1];
        n_out_pix.out_2     = avg[2];
        n_out_pix.out_3     = r_s1_ctl.has_alpha ? avg[3] : '0;
        n_out_pix.frame_end = r_s1_ctl.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_acc && i_ctl.emit) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && i_ctl.emit) begin
            r_s1_ctl <= i_ctl;
            r_s1_hs  <= i_hs;
        end
        if (s1_go) begin
            r_out_pix <= n_out_pix;
        end
    end

    assign o_s1_vld  = r_s1_vld;
    assign o_out_vld = r_out_vld;
    assign o_out_pix = r_out_pix;

endmodule

// ===== design/box_downsample_by_two.sv =====
// 2x2 box downscaler: one source pixel accepted per clock while o_in_stall is low.
// A block-completing pixel passes the combine register, then the output
// register, before it shows on o_out_valid; the single-port line buffer
// serves at most one read or one write per accepted pixel.
// Reset (i_rst_n low, synchronous): 64x64, four components, frame restarts.
module box_downsample_by_two #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [bdd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdd_pkg::CFG_W-1:0]      i_cfg_data,
    // Source pixel channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bdd_pkg::t_pix_in               i_in_pix,
    // Output pixel channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bdd_pkg::t_pix_out              o_out_pix
);
    import bdd_pkg::*;

    // One line-buffer entry holds the four pair sums of one output column
    localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int AW    = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;

    logic        in_acc;
    logic        lb_wr;
    logic        lb_rd;
    logic [AW-1:0] lb_addr;
    t_psum_quad  hs;
    t_psum_quad  lb_rdata;
    t_front      front_ctl;
    logic        s1_vld;

    // Transaction on the source side: valid with no stall
    assign in_acc = i_in_valid && !o_in_stall;

    // Front end: clamp dimensions, track raster position, form pair sums,
    // and steer even source rows into the line buffer
    bdd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (in_acc),
        .i_pix      (i_in_pix),
        .o_lb_wr    (lb_wr),
        .o_lb_rd    (lb_rd),
        .o_lb_addr  (lb_addr),
        .o_hs       (hs),
        .o_ctl      (front_ctl)
    );

    // Pair sums of the even row wait here for the odd row below; the read
    // is issued on the accept edge so its data lines up with the combine stage
    bdd_line_buf #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_wr    (lb_wr),
        .i_rd    (lb_rd),
        .i_addr  (lb_addr),
        .i_wdata (hs),
        .o_rdata (lb_rdata)
    );

    // Combine stage and output register; stall the source only when the
    // combine register is full and the output register cannot drain
    bdd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_ctl       (front_ctl),
        .i_hs        (hs),
        .i_line      (lb_rdata),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_s1_vld    (s1_vld),
        .o_out_vld   (o_out_valid),
        .o_out_pix   (o_out_pix)
    );

    // Line buffer port is never asked to read and write at once
    a_lb_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(lb_wr && lb_rd))
        else $error("line buffer read and write in the same cycle");

    // A block-completing transaction always lands in the combine register
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && front_ctl.emit) |=> s1_vld)
        else $error("emitting transaction dropped");

    // An output only appears after the combine register held a result
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s1_vld))
        else $error("output valid without combine stage data");

endmodule
